// ----- rtl/core/mlt_pkg.sv -----
// Shared types and constants of the MAC learning table.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mlt_pkg;

    localparam int MLT_DEPTH    = 32;
    localparam int MAC_W        = 48;
    localparam int PORT_W       = 8;
    localparam int VLAN_W       = 12;
    localparam int TIME_W       = 32;
    localparam int ID_W         = 16;
    localparam int ID_LOW_W     = 12;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ID_BASE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TCAM_STAGE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_ACTION = 4'd3;

    localparam logic [31:0] AGE_LIMIT_RST = 32'd300;
    localparam logic [15:0] ID_BASE_RST   = 16'd0;
    localparam logic [7:0]  STAGE_RST     = 8'd2;
    localparam logic [7:0]  ACTION_RST    = 8'd0;

    typedef enum logic [1:0] {
        FUNC_LEARN      = 2'd0,
        FUNC_ADD_STATIC = 2'd1,
        FUNC_DELETE     = 2'd2,
        FUNC_AGE        = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_INSTALL = 2'd1,
        OP_REMOVE  = 2'd2
    } tcam_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] age_limit;
        logic [15:0] table_id_base;
        logic [7:0]  tcam_stage;
        logic [7:0]  forward_action;
    } cfg_t;

    // one table slot; tent marks an entry placed early during a learn or add-static scan
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [VLAN_W-1:0] vlan;
        logic [TIME_W-1:0] stamp;
        logic              stat;
        logic              tent;
    } slot_t;

    typedef struct packed {
        logic en;
        logic cancel;
        logic clr;
    } ring_ctl_t;

endpackage

// ----- rtl/core/mlt_cell.sv -----
// One slot of the rotating slot ring.
// Depends on mlt_pkg (slot_t, ring_ctl_t).
`timescale 1ns / 1ps

module mlt_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  mlt_pkg::ring_ctl_t ctl,
    input  mlt_pkg::slot_t    rec_in,
    output mlt_pkg::slot_t    rec
);

    mlt_pkg::slot_t rec_reg;
    mlt_pkg::slot_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.en)
        begin
            // a tentative entry made obsolete by a later match is dropped in flight
            if (ctl.cancel && rec_in.tent)
            begin
                rec_next = '0;
            end
            else
            begin
                rec_next = rec_in;
                if (ctl.clr)
                begin
                    rec_next.tent = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

// ----- rtl/core/mlt_cfg.sv -----
// Configuration register file: age limit, table id base, stage, action.
// Depends on mlt_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module mlt_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlt_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mlt_pkg::cfg_t                      cfg
);

    mlt_pkg::cfg_t cfg_reg;
    mlt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                mlt_pkg::REG_AGE_LIMIT:      cfg_next.age_limit      = cfg_data;
                mlt_pkg::REG_TABLE_ID_BASE:  cfg_next.table_id_base  = cfg_data[15:0];
                mlt_pkg::REG_TCAM_STAGE:     cfg_next.tcam_stage     = cfg_data[7:0];
                mlt_pkg::REG_FORWARD_ACTION: cfg_next.forward_action = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.age_limit      <= mlt_pkg::AGE_LIMIT_RST;
            cfg_reg.table_id_base  <= mlt_pkg::ID_BASE_RST;
            cfg_reg.tcam_stage     <= mlt_pkg::STAGE_RST;
            cfg_reg.forward_action <= mlt_pkg::ACTION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/mlt_ctrl.sv -----
// Request sequencer: looks at the ring head each cycle, writes the slot back
// to the ring tail, and builds TCAM command responses. Depends on mlt_pkg.
`timescale 1ns / 1ps

module mlt_ctrl
#(
    parameter int TABLE_DEPTH = mlt_pkg::MLT_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      func,
    input  logic [mlt_pkg::MAC_W-1:0]       mac,
    input  logic [mlt_pkg::PORT_W-1:0]      egress_port,
    input  logic [mlt_pkg::VLAN_W-1:0]      vlan_id,
    input  logic [mlt_pkg::TIME_W-1:0]      now_time,
    input  mlt_pkg::cfg_t                   cfg,
    input  mlt_pkg::slot_t                  head,
    output mlt_pkg::slot_t                  wb,
    output mlt_pkg::ring_ctl_t              ring,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [1:0]                      status,
    output logic [1:0]                      tcam_op,
    output logic [7:0]                      stage_out,
    output logic [mlt_pkg::ID_W-1:0]        table_id,
    output logic [mlt_pkg::MAC_W-1:0]       mac_out,
    output logic [7:0]                      action_out,
    output logic [mlt_pkg::PORT_W-1:0]      port_out,
    output logic                            last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

    mlt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic hit_reg, hit_next;
    logic tent_reg, tent_next;
    logic pend_reg, pend_next;
    logic [mlt_pkg::MAC_W-1:0] pend_mac_reg, pend_mac_next;

    mlt_pkg::func_t              func_reg;
    logic [mlt_pkg::MAC_W-1:0]   mac_reg;
    logic [mlt_pkg::PORT_W-1:0]  port_reg;
    logic [mlt_pkg::VLAN_W-1:0]  vlan_reg;
    logic [mlt_pkg::TIME_W-1:0]  now_reg;

    logic                       rsp_valid_reg, rsp_valid_next;
    mlt_pkg::status_t           rsp_status_reg;
    mlt_pkg::tcam_op_t          rsp_op_reg;
    logic [7:0]                 rsp_stage_reg;
    logic [mlt_pkg::ID_W-1:0]   rsp_id_reg;
    logic [mlt_pkg::MAC_W-1:0]  rsp_mac_reg;
    logic [7:0]                 rsp_action_reg;
    logic [mlt_pkg::PORT_W-1:0] rsp_port_reg;
    logic                       rsp_last_reg;

    logic accept;
    logic out_free;
    logic match;
    logic expired;
    logic is_add;
    logic [mlt_pkg::TIME_W-1:0] age;

    logic                       load;
    mlt_pkg::status_t           ld_status;
    mlt_pkg::tcam_op_t          ld_op;
    logic [mlt_pkg::MAC_W-1:0]  ld_mac;
    logic                       ld_last;

    assign req_stall = (state_reg != mlt_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign match   = head.valid && (head.mac == mac_reg) && !hit_reg;
    assign age     = now_reg - head.stamp;
    assign expired = head.valid && !head.stat && (age >= cfg.age_limit);
    assign is_add  = (func_reg == mlt_pkg::FUNC_ADD_STATIC);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = mlt_pkg::S_SCAN;
                end
            end
            mlt_pkg::S_SCAN:
            begin
                if (ring.en && (cnt_reg == CNT_LAST))
                begin
                    state_next = mlt_pkg::S_DONE;
                end
            end
            mlt_pkg::S_DONE:
            begin
                if (((func_reg == mlt_pkg::FUNC_AGE) && !pend_reg) || out_free)
                begin
                    state_next = mlt_pkg::S_IDLE;
                end
            end
            default: state_next = mlt_pkg::S_IDLE;
        endcase
    end

    // outputs: ring control, slot write-back, response load
    always_comb
    begin
        wb            = head;
        wb.tent       = 1'b0;
        ring          = '0;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        tent_next     = tent_reg;
        pend_next     = pend_reg;
        pend_mac_next = pend_mac_reg;
        load          = 1'b0;
        ld_status     = mlt_pkg::STAT_OK;
        ld_op         = mlt_pkg::OP_NONE;
        ld_mac        = mac_reg;
        ld_last       = 1'b1;
        case (state_reg)
            mlt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    tent_next = 1'b0;
                    pend_next = 1'b0;
                end
            end
            mlt_pkg::S_SCAN:
            begin
                ring.en  = 1'b1;
                // marks left from the previous pass are wiped on the first shift
                ring.clr = (cnt_reg == '0);
                case (func_reg)
                    mlt_pkg::FUNC_LEARN, mlt_pkg::FUNC_ADD_STATIC:
                    begin
                        if (match)
                        begin
                            wb.port  = port_reg;
                            wb.stamp = now_reg;
                            if (is_add)
                            begin
                                wb.vlan = vlan_reg;
                                wb.stat = 1'b1;
                            end
                            ring.cancel = tent_reg;
                            hit_next    = 1'b1;
                        end
                        else if (!head.valid && !hit_reg && !tent_reg)
                        begin
                            // lowest free slot taken now, dropped if a match turns up
                            wb.valid  = 1'b1;
                            wb.mac    = mac_reg;
                            wb.port   = port_reg;
                            wb.vlan   = is_add ? vlan_reg : '0;
                            wb.stamp  = now_reg;
                            wb.stat   = is_add;
                            wb.tent   = 1'b1;
                            tent_next = 1'b1;
                        end
                    end
                    mlt_pkg::FUNC_DELETE:
                    begin
                        if (match)
                        begin
                            wb       = '0;
                            hit_next = 1'b1;
                        end
                    end
                    mlt_pkg::FUNC_AGE:
                    begin
                        if (expired)
                        begin
                            // hold one removal back so the final one can carry last
                            if (pend_reg)
                            begin
                                if (out_free)
                                begin
                                    load          = 1'b1;
                                    ld_op         = mlt_pkg::OP_REMOVE;
                                    ld_mac        = pend_mac_reg;
                                    ld_last       = 1'b0;
                                    wb            = '0;
                                    pend_mac_next = head.mac;
                                end
                                else
                                begin
                                    ring.en = 1'b0;
                                end
                            end
                            else
                            begin
                                wb            = '0;
                                pend_next     = 1'b1;
                                pend_mac_next = head.mac;
                            end
                        end
                    end
                    default: wb = head;
                endcase
                if (ring.en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    ring.clr = 1'b0;
                end
            end
            mlt_pkg::S_DONE:
            begin
                case (func_reg)
                    mlt_pkg::FUNC_LEARN, mlt_pkg::FUNC_ADD_STATIC:
                    begin
                        load = out_free;
                        if (hit_reg || tent_reg)
                        begin
                            ld_op = mlt_pkg::OP_INSTALL;
                        end
                        else
                        begin
                            ld_status = mlt_pkg::STAT_FULL;
                        end
                    end
                    mlt_pkg::FUNC_DELETE:
                    begin
                        load = out_free;
                        if (hit_reg)
                        begin
                            ld_op = mlt_pkg::OP_REMOVE;
                        end
                        else
                        begin
                            ld_status = mlt_pkg::STAT_NOT_FOUND;
                        end
                    end
                    mlt_pkg::FUNC_AGE:
                    begin
                        load   = pend_reg && out_free;
                        ld_op  = mlt_pkg::OP_REMOVE;
                        ld_mac = pend_mac_reg;
                        if (load)
                        begin
                            pend_next = 1'b0;
                        end
                    end
                    default: load = 1'b0;
                endcase
            end
            default: ring = '0;
        endcase
    end

    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlt_pkg::S_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            tent_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            tent_reg      <= tent_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_mac_reg <= pend_mac_next;
        if (accept)
        begin
            func_reg <= mlt_pkg::func_t'(func);
            mac_reg  <= mac;
            port_reg <= egress_port;
            vlan_reg <= vlan_id;
            now_reg  <= now_time;
        end
        if (load)
        begin
            rsp_status_reg <= ld_status;
            rsp_op_reg     <= ld_op;
            rsp_last_reg   <= ld_last;
            if (ld_op != mlt_pkg::OP_NONE)
            begin
                rsp_stage_reg <= cfg.tcam_stage;
                rsp_id_reg    <= cfg.table_id_base
                                 + {{(mlt_pkg::ID_W - mlt_pkg::ID_LOW_W){1'b0}},
                                    ld_mac[mlt_pkg::ID_LOW_W-1:0]};
                rsp_mac_reg   <= ld_mac;
            end
            else
            begin
                rsp_stage_reg <= '0;
                rsp_id_reg    <= '0;
                rsp_mac_reg   <= '0;
            end
            if (ld_op == mlt_pkg::OP_INSTALL)
            begin
                rsp_action_reg <= cfg.forward_action;
                rsp_port_reg   <= port_reg;
            end
            else
            begin
                rsp_action_reg <= '0;
                rsp_port_reg   <= '0;
            end
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign tcam_op    = rsp_op_reg;
    assign stage_out  = rsp_stage_reg;
    assign table_id   = rsp_id_reg;
    assign mac_out    = rsp_mac_reg;
    assign action_out = rsp_action_reg;
    assign port_out   = rsp_port_reg;
    assign last       = rsp_last_reg;

endmodule

// ----- rtl/core/mac_learning_table_top.sv -----
// Top level of the MAC learning table: slot ring, sequencer, config registers.
// Depends on mlt_pkg, mlt_cell, mlt_cfg and mlt_ctrl.
`timescale 1ns / 1ps

// Layer-2 MAC table of TABLE_DEPTH slots kept in a ring of cells that rotates
// by one slot per cycle while not halted. One request is handled at a time:
// it is taken, then the ring makes one full turn of TABLE_DEPTH slots while
// the sequencer checks and rewrites the slot at the head, then the response
// is posted. An age sweep halts the ring while a removal waits on a stalled
// response register. Learn and add-static give one response, delete gives
// one, an age sweep gives one per removed entry (possibly none). Reset
// clears the whole table at once; there is no clearing pass. Configuration
// is taken every cycle.

module mac_learning_table_top
#(
    parameter int TABLE_DEPTH = mlt_pkg::MLT_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      func,
    input  logic [mlt_pkg::MAC_W-1:0]       mac,
    input  logic [mlt_pkg::PORT_W-1:0]      egress_port,
    input  logic [mlt_pkg::VLAN_W-1:0]      vlan_id,
    input  logic [mlt_pkg::TIME_W-1:0]      now_time,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [1:0]                      status,
    output logic [1:0]                      tcam_op,
    output logic [7:0]                      stage_out,
    output logic [mlt_pkg::ID_W-1:0]        table_id,
    output logic [mlt_pkg::MAC_W-1:0]       mac_out,
    output logic [7:0]                      action_out,
    output logic [mlt_pkg::PORT_W-1:0]      port_out,
    output logic                            last
);

    mlt_pkg::cfg_t      cfg;
    mlt_pkg::slot_t     wb;
    mlt_pkg::ring_ctl_t ring;
    mlt_pkg::slot_t     ring_q   [TABLE_DEPTH];
    mlt_pkg::ring_ctl_t cell_ctl [TABLE_DEPTH];

    mlt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // slots move toward index 0; the head's write-back enters at the tail
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign cell_ctl[i] = '{en: ring.en, cancel: ring.cancel, clr: 1'b0};
            mlt_cell u_cell
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (cell_ctl[i]),
                .rec_in (wb),
                .rec    (ring_q[i])
            );
        end
        else
        begin : g_body
            assign cell_ctl[i] = ring;
            mlt_cell u_cell
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (cell_ctl[i]),
                .rec_in (ring_q[i+1]),
                .rec    (ring_q[i])
            );
        end
    end

    mlt_ctrl
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .mac         (mac),
        .egress_port (egress_port),
        .vlan_id     (vlan_id),
        .now_time    (now_time),
        .cfg         (cfg),
        .head        (ring_q[0]),
        .wb          (wb),
        .ring        (ring),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .tcam_op     (tcam_op),
        .stage_out   (stage_out),
        .table_id    (table_id),
        .mac_out     (mac_out),
        .action_out  (action_out),
        .port_out    (port_out),
        .last        (last)
    );

endmodule

// ----- rtl/core/mlt_checker.sv -----
// Port-level checks of the MAC learning table, bound to the top level.
// Depends on mlt_pkg (status and command codes) and mac_learning_table_top.
`timescale 1ns / 1ps

module mlt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [1:0]  status,
    input logic [1:0]  tcam_op,
    input logic [7:0]  stage_out,
    input logic [15:0] table_id,
    input logic [47:0] mac_out,
    input logic [7:0]  action_out,
    input logic [7:0]  port_out,
    input logic        last
);

    // a taken request keeps the input side closed for the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while a request is in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(mac_out) && $stable(last))
        else $error("stalled response changed");

    // full and not-found responses carry no command and end their request
    a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (tcam_op == mlt_pkg::OP_NONE) |->
            last && (stage_out == 8'd0) && (table_id == 16'd0) && (mac_out == 48'd0))
        else $error("response without command has command fields");

    a_err_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != mlt_pkg::STAT_OK) |-> (tcam_op == mlt_pkg::OP_NONE))
        else $error("error status with a TCAM command");

    a_remove_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (tcam_op != mlt_pkg::OP_INSTALL) |->
            (action_out == 8'd0) && (port_out == 8'd0))
        else $error("action or port set outside an install");

endmodule

bind mac_learning_table_top mlt_checker u_mlt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .tcam_op    (tcam_op),
    .stage_out  (stage_out),
    .table_id   (table_id),
    .mac_out    (mac_out),
    .action_out (action_out),
    .port_out   (port_out),
    .last       (last)
);
